### rtl/core/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared sizes, codes and controller/datapath types for the text console.
// ----------------------------------------------------------------------------
package tccs_pkg;

	// Screen geometry
	localparam int COLS         = 80;
	localparam int ROWS         = 25;
	localparam int CELL_COUNT   = COLS * ROWS;
	localparam int SCROLL_CELLS = COLS * (ROWS - 1);
	localparam int ADDR_W       = $clog2(CELL_COUNT);
	localparam int COL_W        = $clog2(COLS);
	localparam int ROW_W        = $clog2(ROWS);

	// Fixed field widths of the ports
	localparam int CMD_W        = 2;
	localparam int CHAR_W       = 8;
	localparam int RD_ROW_W     = 5;
	localparam int RD_COL_W     = 7;
	localparam int CELL_W       = 16;
	localparam int CUR_COL_W    = 7;
	localparam int CUR_ROW_W    = 5;
	localparam int COLOUR_W     = 4;
	localparam int CFG_IDX_W    = 1;

	// Commands
	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FORE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACK = 1'b1;

	// Characters and colours
	localparam logic [CHAR_W-1:0]   NL_CHAR     = 8'h0A;
	localparam logic [CHAR_W-1:0]   BLANK_CHAR  = 8'h20;
	localparam logic [COLOUR_W-1:0] FORE_RESET  = 4'hF;
	localparam logic [COLOUR_W-1:0] BACK_RESET  = 4'h0;
	localparam logic [CELL_W-1:0]   RESET_BLANK = {BACK_RESET, FORE_RESET, BLANK_CHAR};

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_COPY,
		ST_DRAIN,
		ST_FILL,
		ST_CLEAR,
		ST_RD_WAIT,
		ST_RD_DATA,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_INIT,
		OP_CLEAR,
		OP_PUT,
		OP_COPY,
		OP_FILL,
		OP_CAPTURE,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} ctrl_t;

	typedef struct packed {
		logic sweep_end;   // sweep counter at last cell
		logic copy_last;   // scroll copy at last source cell
		logic put_scroll;  // pending put runs off the bottom row
		logic out_free;    // output register can take a result
	} status_t;

endpackage

### rtl/core/tccs_ctrl.sv
// ----------------------------------------------------------------------------
// tccs_ctrl
// Sequencer: takes one item at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
module tccs_ctrl
	import tccs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic [CMD_W-1:0] command,
	input  status_t          status,
	output logic             item_stall,
	output ctrl_t            ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (status.sweep_end) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (item_valid) begin
					case (command)
						CMD_PUT:   state_d = ST_PUT;
						CMD_CLEAR: state_d = ST_CLEAR;
						CMD_READ:  state_d = ST_RD_WAIT;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_PUT:     state_d = status.put_scroll ? ST_COPY : ST_DONE;
			ST_COPY: begin
				if (status.copy_last) state_d = ST_DRAIN;
			end
			ST_DRAIN:   state_d = ST_FILL;
			ST_FILL: begin
				if (status.sweep_end) state_d = ST_DONE;
			end
			ST_CLEAR: begin
				if (status.sweep_end) state_d = ST_DONE;
			end
			ST_RD_WAIT: state_d = ST_RD_DATA;
			ST_RD_DATA: state_d = ST_DONE;
			ST_DONE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default:    state_d = ST_INIT;
		endcase
	end

	// outputs
	always_comb begin
		ctrl.op    = OP_IDLE;
		item_stall = 1'b1;
		case (state_q)
			ST_INIT:    ctrl.op = OP_INIT;
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) ctrl.op = OP_LOAD;
			end
			ST_PUT:     ctrl.op = OP_PUT;
			ST_COPY:    ctrl.op = OP_COPY;
			ST_DRAIN:   ctrl.op = OP_IDLE;
			ST_FILL:    ctrl.op = OP_FILL;
			ST_CLEAR:   ctrl.op = OP_CLEAR;
			ST_RD_WAIT: ctrl.op = OP_IDLE;
			ST_RD_DATA: ctrl.op = OP_CAPTURE;
			ST_DONE: begin
				if (status.out_free) ctrl.op = OP_EMIT;
			end
			default:    ctrl.op = OP_IDLE;
		endcase
	end

endmodule

### rtl/core/tccs_dp.sv
// ----------------------------------------------------------------------------
// tccs_dp
// Screen store, cursor, colour registers, sweep counter and result register.
// ----------------------------------------------------------------------------
module tccs_dp
	import tccs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_t                ctrl,
	output status_t              status,
	// item fields
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [RD_ROW_W-1:0]  read_row,
	input  logic [RD_COL_W-1:0]  read_col,
	// register writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOUR_W-1:0]  cfg_data,
	// result
	input  logic                 result_stall,
	output logic                 result_valid,
	output logic [CELL_W-1:0]    cell_value,
	output logic [CUR_COL_W-1:0] cursor_col,
	output logic [CUR_ROW_W-1:0] cursor_row,
	output logic                 scrolled
);

	logic [CELL_W-1:0]   mem [CELL_COUNT];

	logic [COLOUR_W-1:0] fore_q;
	logic [COLOUR_W-1:0] back_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [ADDR_W-1:0]   row_base_q;
	logic [ADDR_W-1:0]   sweep_q;

	logic [CHAR_W-1:0]   char_q;
	logic [ADDR_W-1:0]   rd_addr_q;
	logic                rd_ok_q;
	logic [CELL_W-1:0]   res_cell_q;
	logic                scrolled_q;

	logic                cp_wr_s1;
	logic [ADDR_W-1:0]   cp_addr_s1;
	logic [CELL_W-1:0]   rd_data_s1;

	logic                result_valid_q;
	logic [CELL_W-1:0]   cell_value_q;
	logic [CUR_COL_W-1:0] cursor_col_q;
	logic [CUR_ROW_W-1:0] cursor_row_q;
	logic                scrolled_out_q;

	logic [CELL_W-1:0]   blank;
	logic [ADDR_W-1:0]   cur_addr;
	logic                is_nl;
	logic                wrap;
	logic                bottom;
	logic                sweep_end;
	logic [31:0]         rd_lin;
	logic                rd_in_range;
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [CELL_W-1:0]   wdata;
	logic [ADDR_W-1:0]   raddr;

	assign blank     = {back_q, fore_q, BLANK_CHAR};
	assign cur_addr  = row_base_q + ADDR_W'(col_q);
	assign is_nl     = (char_q == NL_CHAR);
	assign wrap      = is_nl || (col_q == COL_W'(COLS - 1));
	assign bottom    = (row_q == ROW_W'(ROWS - 1));
	assign sweep_end = (sweep_q == ADDR_W'(CELL_COUNT - 1));

	assign rd_lin      = 32'(read_row) * 32'(COLS) + 32'(read_col);
	assign rd_in_range = (32'(read_row) < 32'(ROWS)) && (32'(read_col) < 32'(COLS));

	assign status.sweep_end  = sweep_end;
	assign status.copy_last  = (sweep_q == ADDR_W'(SCROLL_CELLS - 1));
	assign status.put_scroll = wrap && bottom;
	assign status.out_free   = !result_valid_q || !result_stall;

	// write port select; a pending copy write never overlaps another writer
	always_comb begin
		we    = 1'b0;
		waddr = sweep_q;
		wdata = blank;
		if (cp_wr_s1) begin
			we    = 1'b1;
			waddr = cp_addr_s1;
			wdata = rd_data_s1;
		end else begin
			case (ctrl.op)
				OP_INIT: begin
					we    = 1'b1;
					wdata = RESET_BLANK;
				end
				OP_CLEAR, OP_FILL: we = 1'b1;
				OP_PUT: begin
					we    = !is_nl;
					waddr = cur_addr;
					wdata = {back_q, fore_q, char_q};
				end
				default: we = 1'b0;
			endcase
		end
	end

	assign raddr = (ctrl.op == OP_COPY) ? sweep_q + ADDR_W'(COLS) : rd_addr_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_data_s1 <= mem[raddr];
	end

	// item and result payload
	always_ff @(posedge clk) begin
		cp_addr_s1 <= sweep_q;
		case (ctrl.op)
			OP_LOAD: begin
				char_q     <= char_code;
				rd_ok_q    <= rd_in_range;
				rd_addr_q  <= rd_in_range ? ADDR_W'(rd_lin) : '0;
				res_cell_q <= '0;
				scrolled_q <= 1'b0;
			end
			OP_PUT: begin
				if (wrap && bottom) scrolled_q <= 1'b1;
			end
			OP_CAPTURE: begin
				res_cell_q <= rd_ok_q ? rd_data_s1 : '0;
			end
			default: begin
			end
		endcase
		if (ctrl.op == OP_EMIT) begin
			cell_value_q   <= res_cell_q;
			cursor_col_q   <= CUR_COL_W'(col_q);
			cursor_row_q   <= CUR_ROW_W'(row_q);
			scrolled_out_q <= scrolled_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_q         <= FORE_RESET;
			back_q         <= BACK_RESET;
			col_q          <= '0;
			row_q          <= '0;
			row_base_q     <= '0;
			sweep_q        <= '0;
			cp_wr_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FORE: fore_q <= cfg_data;
					CFG_BACK: back_q <= cfg_data;
					default:  fore_q <= fore_q;
				endcase
			end

			cp_wr_s1 <= (ctrl.op == OP_COPY);

			case (ctrl.op)
				OP_INIT, OP_CLEAR, OP_FILL: begin
					sweep_q <= sweep_end ? '0 : sweep_q + 1'b1;
				end
				OP_COPY: sweep_q <= sweep_q + 1'b1;
				default: sweep_q <= sweep_q;
			endcase

			case (ctrl.op)
				OP_CLEAR: begin
					col_q      <= '0;
					row_q      <= '0;
					row_base_q <= '0;
				end
				OP_PUT: begin
					if (wrap) begin
						col_q <= '0;
						if (!bottom) begin
							row_q      <= row_q + 1'b1;
							row_base_q <= row_base_q + ADDR_W'(COLS);
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				default: begin
				end
			endcase

			if (ctrl.op == OP_EMIT) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign cell_value   = cell_value_q;
	assign cursor_col   = cursor_col_q;
	assign cursor_row   = cursor_row_q;
	assign scrolled     = scrolled_out_q;

endmodule

### rtl/core/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console engine: ROWS x COLS screen of 16-bit cells with a cursor.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  item     | item_valid / item_stall    | command, char_code, read_row, read_col
//  result   | result_valid / result_stall| cell_value, cursor_col, cursor_row,
//           |                            | scrolled
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
//  One item at a time; a read waits on the store before it captures the cell.
//  A put that runs off the bottom row copies the upper COLS*(ROWS-1) cells one
//  row up, passes a drain step, then fills the COLS bottom cells with blanks.
//  Clear sweeps all ROWS*COLS cells, one per cycle. After reset a clearing pass
//  fills all ROWS*COLS cells with blanks in the reset colours; item_stall stays
//  high meanwhile. Results sit in an output register; a stalled result holds
//  the sequencer in its final step until taken. cfg_ready is always high.
//
module text_console_cursor_scroll
	import tccs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// item channel
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [CMD_W-1:0]     command,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [RD_ROW_W-1:0]  read_row,
	input  logic [RD_COL_W-1:0]  read_col,
	// result channel
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [CELL_W-1:0]    cell_value,
	output logic [CUR_COL_W-1:0] cursor_col,
	output logic [CUR_ROW_W-1:0] cursor_row,
	output logic                 scrolled,
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOUR_W-1:0]  cfg_data
);

	ctrl_t   ctrl;
	status_t status;

	// colour registers can always be written
	assign cfg_ready = 1'b1;

	tccs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.command    (command),
		.status     (status),
		.item_stall (item_stall),
		.ctrl       (ctrl)
	);

	tccs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.status       (status),
		.char_code    (char_code),
		.read_row     (read_row),
		.read_col     (read_col),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.cell_value   (cell_value),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row),
		.scrolled     (scrolled)
	);

endmodule

### sim/text_console_cursor_scroll_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_tb
// Self-checking bench for the text console. A shadow copy of the screen, the
// cursor and the colour registers predicts every result. Items and results
// move with random gaps and stalls. Typed lines, newline bursts, reads,
// clears and stray commands run under several colour settings.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_tb;
	import tccs_pkg::*;

	localparam int CLK_PERIOD      = 8;
	localparam int ITEMS_PER_PHASE = 280;
	localparam int QUIET_LIMIT     = 20000;  // must outlast a full scroll or clear
	localparam int TAIL_CYCLES     = 20;
	localparam int MAX_SHOWN       = 10;

	// command code the block does not decode
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	// colour plan of the random phases; the last phase draws its own
	localparam logic [COLOUR_W-1:0] FORE_PLAN [4] = '{4'hF, 4'h0, 4'h0, 4'hF};
	localparam logic [COLOUR_W-1:0] BACK_PLAN [4] = '{4'h0, 4'h0, 4'hF, 4'hF};

	typedef struct packed {
		logic [CELL_W-1:0]    cell_value;
		logic [CUR_COL_W-1:0] cursor_col;
		logic [CUR_ROW_W-1:0] cursor_row;
		logic                 scrolled;
	} console_result_t;

	// Shadow of the console: screen store, cursor and colours. Every
	// accepted item is applied here and its report queued for the check.
	class console_mirror;
		logic [CELL_W-1:0]   screen [CELL_COUNT];
		int unsigned         col;
		int unsigned         row;
		logic [COLOUR_W-1:0] fore;
		logic [COLOUR_W-1:0] back;
		console_result_t     due_reports [$];
		int failures    = 0;
		int checked     = 0;
		int puts        = 0;
		int reads       = 0;
		int blind_reads = 0;
		int clears      = 0;
		int idle_cmds   = 0;
		int scrolls     = 0;
		int wraps       = 0;
		int reg_writes  = 0;

		function new();
			fore = FORE_RESET;
			back = BACK_RESET;
			blank_screen();
			col = 0;
			row = 0;
		endfunction

		function logic [CELL_W-1:0] blank();
			return {back, fore, BLANK_CHAR};
		endfunction

		function void blank_screen();
			for (int i = 0; i < CELL_COUNT; i++)
				screen[i] = blank();
		endfunction

		function void scroll_screen();
			for (int i = 0; i < SCROLL_CELLS; i++)
				screen[i] = screen[i + COLS];
			for (int i = SCROLL_CELLS; i < CELL_COUNT; i++)
				screen[i] = blank();
			row = ROWS - 1;
			col = 0;
			scrolls++;
		endfunction

		// returns 1 when the put pushed the cursor past the bottom row
		function bit type_byte(logic [CHAR_W-1:0] ch);
			if (ch == NL_CHAR) begin
				col = 0;
				row++;
			end else begin
				screen[row * COLS + col] = {back, fore, ch};
				col++;
				if (col >= COLS) begin
					col = 0;
					row++;
					wraps++;
				end
			end
			if (row >= ROWS) begin
				scroll_screen();
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void set_colour(logic [CFG_IDX_W-1:0] idx, logic [COLOUR_W-1:0] val);
			reg_writes++;
			case (idx)
				CFG_FORE: fore = val;
				CFG_BACK: back = val;
				default: ;
			endcase
		endfunction

		function void apply_item(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
				logic [RD_ROW_W-1:0] rr, logic [RD_COL_W-1:0] rc);
			console_result_t r;
			r = '0;
			case (cmd)
				CMD_PUT: begin
					puts++;
					r.scrolled = type_byte(ch);
				end
				CMD_CLEAR: begin
					clears++;
					blank_screen();
					col = 0;
					row = 0;
				end
				CMD_READ: begin
					reads++;
					if (rr < ROWS && rc < COLS)
						r.cell_value = screen[rr * COLS + rc];
					else
						blind_reads++;
				end
				default: idle_cmds++;
			endcase
			r.cursor_col = col[CUR_COL_W-1:0];
			r.cursor_row = row[CUR_ROW_W-1:0];
			due_reports.push_back(r);
		endfunction

		function void match_result(console_result_t got);
			console_result_t want;
			if (due_reports.size() == 0) begin
				failures++;
				if (failures <= MAX_SHOWN)
					$display("%0t: result with nothing pending: cell %h col %0d row %0d scr %0b",
						$realtime, got.cell_value, got.cursor_col, got.cursor_row,
						got.scrolled);
				return;
			end
			want = due_reports.pop_front();
			checked++;
			if (got.cell_value !== want.cell_value || got.cursor_col !== want.cursor_col ||
					got.cursor_row !== want.cursor_row || got.scrolled !== want.scrolled) begin
				failures++;
				if (failures <= MAX_SHOWN)
					$display("%0t: result %0d: cell %h/%h col %0d/%0d row %0d/%0d scr %0b/%0b %s",
						$realtime, checked, want.cell_value, got.cell_value,
						want.cursor_col, got.cursor_col, want.cursor_row, got.cursor_row,
						want.scrolled, got.scrolled, "(expected/actual)");
			end
		endfunction
	endclass

	// ------------------------------------------------------------------
	// Block and its inputs; every input is known from time zero
	// ------------------------------------------------------------------
	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 item_valid  = 1'b0;
	logic                 item_stall;
	logic [CMD_W-1:0]     command     = CMD_PUT;
	logic [CHAR_W-1:0]    char_code   = '0;
	logic [RD_ROW_W-1:0]  read_row    = '0;
	logic [RD_COL_W-1:0]  read_col    = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [CELL_W-1:0]    cell_value;
	logic [CUR_COL_W-1:0] cursor_col;
	logic [CUR_ROW_W-1:0] cursor_row;
	logic                 scrolled;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = CFG_FORE;
	logic [COLOUR_W-1:0]  cfg_data    = '0;

	console_mirror mirror = new();

	bit item_burst   = 1'b0;  // sender runs with no gaps while set
	bit take_burst   = 1'b0;  // receiver takes with no stalls while set
	int items_sent   = 0;
	int quiet_cycles = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	text_console_cursor_scroll dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.char_code    (char_code),
		.read_row     (read_row),
		.read_col     (read_col),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cell_value   (cell_value),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row),
		.scrolled     (scrolled),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// ------------------------------------------------------------------
	// Item side. Valid stays up after an accept so that a zero gap gives
	// back-to-back items; the next call, or end_items, decides what
	// happens at the following falling edge.
	// ------------------------------------------------------------------
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
			input logic [RD_ROW_W-1:0] rr, input logic [RD_COL_W-1:0] rc);
		int gap;
		if ($urandom_range(0, 39) == 0)
			item_burst = !item_burst;
		gap = item_burst ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		command    <= cmd;
		char_code  <= ch;
		read_row   <= rr;
		read_col   <= rc;
		do @(posedge clk); while (item_stall);
		mirror.apply_item(cmd, ch, rr, rc);
		items_sent++;
	endtask

	task automatic end_items();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	// wait until every report is in, then let the sequencer settle
	task automatic drain();
		end_items();
		while (mirror.due_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// cfg_valid is left high between the two writes, lowered after
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOUR_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		mirror.set_colour(idx, val);
	endtask

	task automatic set_colours(input logic [COLOUR_W-1:0] f, input logic [COLOUR_W-1:0] b);
		write_reg(CFG_FORE, f);
		write_reg(CFG_BACK, b);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Read one cell: on screen normally, anywhere in the field range if wild
	task automatic peek_cell(input bit wild);
		logic [RD_ROW_W-1:0] rr;
		logic [RD_COL_W-1:0] rc;
		if (wild) begin
			rr = RD_ROW_W'($urandom);
			rc = RD_COL_W'($urandom);
		end else begin
			rr = RD_ROW_W'($urandom_range(0, ROWS - 1));
			rc = RD_COL_W'($urandom_range(0, COLS - 1));
		end
		send_item(CMD_READ, CHAR_W'($urandom), rr, rc);
	endtask

	task automatic put_newline();
		send_item(CMD_PUT, NL_CHAR, RD_ROW_W'($urandom), RD_COL_W'($urandom));
	endtask

	// A typed line: a run of non-newline bytes with the odd read mixed in,
	// usually closed by a newline. Long runs wrap at the row end.
	task automatic type_line();
		int len;
		logic [CHAR_W-1:0] ch;
		len = $urandom_range(1, 100);
		repeat (len) begin
			if ($urandom_range(0, 9) == 0) begin
				peek_cell(1'b0);
			end else begin
				ch = CHAR_W'($urandom);
				if (ch == NL_CHAR)
					ch = BLANK_CHAR;
				send_item(CMD_PUT, ch, RD_ROW_W'($urandom), RD_COL_W'($urandom));
			end
		end
		if ($urandom_range(0, 9) < 7)
			put_newline();
	endtask

	task automatic random_phase(input int quota);
		int first;
		int pick;
		first = items_sent;
		while (items_sent - first < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				type_line();
			else if (pick < 70)
				repeat ($urandom_range(1, 6)) put_newline();
			else if (pick < 84)
				repeat ($urandom_range(1, 8)) peek_cell($urandom_range(0, 3) == 0);
			else if (pick < 87)
				send_item(CMD_CLEAR, CHAR_W'($urandom), RD_ROW_W'($urandom),
					RD_COL_W'($urandom));
			else if (pick < 91)
				repeat ($urandom_range(1, 3))
					send_item(CMD_NONE, CHAR_W'($urandom), RD_ROW_W'($urandom),
						RD_COL_W'($urandom));
			else
				send_item(CMD_W'($urandom), CHAR_W'($urandom), RD_ROW_W'($urandom),
					RD_COL_W'($urandom));
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: stall for a random number of cycles, then take the
	// next report and check it against the oldest prediction.
	// ------------------------------------------------------------------
	initial begin : result_sink
		console_result_t got;
		int hold;
		forever begin
			if ($urandom_range(0, 39) == 0)
				take_burst = !take_burst;
			hold = take_burst ? 0 : $urandom_range(0, 12);
			@(negedge clk);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			got.cell_value = cell_value;
			got.cursor_col = cursor_col;
			got.cursor_row = cursor_row;
			got.scrolled   = scrolled;
			mirror.match_result(got);
		end
	end

	// Watchdog: any transfer on any channel restarts the count
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d reports outstanding",
				$realtime, quiet_cycles, mirror.due_reports.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [COLOUR_W-1:0] f;
		logic [COLOUR_W-1:0] b;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset screen, byte extremes, newline, reads on and off
		// the screen, the undecoded command.
		send_item(CMD_READ, 8'h00, 5'd0, 7'd0);
		send_item(CMD_PUT, 8'h41, 5'd0, 7'd0);
		send_item(CMD_PUT, 8'h00, 5'd31, 7'd127);
		send_item(CMD_PUT, 8'hFF, 5'd0, 7'd0);
		send_item(CMD_PUT, NL_CHAR, 5'd0, 7'd0);
		send_item(CMD_READ, 8'h00, 5'd0, 7'd0);
		send_item(CMD_READ, 8'hFF, 5'd0, 7'd2);
		send_item(CMD_READ, 8'h00, 5'd1, 7'd0);
		send_item(CMD_READ, 8'h00, 5'd25, 7'd0);     // first row below the screen
		send_item(CMD_READ, 8'h00, 5'd31, 7'd127);   // both fields all ones
		send_item(CMD_READ, 8'h00, 5'd0, 7'd80);     // first column past the edge
		send_item(CMD_READ, 8'h00, 5'd24, 7'd79);    // bottom-right cell
		send_item(CMD_NONE, 8'hFF, 5'd31, 7'd127);
		drain();

		// Colour extremes, then a put, a clear in those colours and reads
		set_colours(4'h0, 4'hF);
		send_item(CMD_PUT, 8'h7E, 5'd0, 7'd0);
		send_item(CMD_READ, 8'h00, 5'd1, 7'd0);
		send_item(CMD_CLEAR, 8'h00, 5'd0, 7'd0);
		send_item(CMD_READ, 8'h00, 5'd1, 7'd0);
		send_item(CMD_READ, 8'h00, 5'd24, 7'd79);

		// Walk down to the bottom row; the last newline scrolls
		repeat (ROWS) put_newline();
		send_item(CMD_READ, 8'h00, 5'd24, 7'd0);
		drain();

		for (int p = 0; p < 5; p++) begin
			if (p < 4) begin
				f = FORE_PLAN[p];
				b = BACK_PLAN[p];
			end else begin
				f = COLOUR_W'($urandom);
				b = COLOUR_W'($urandom);
			end
			set_colours(f, b);
			random_phase(ITEMS_PER_PHASE);
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d items: %0d puts, %0d reads (%0d off screen), %0d clears, %0d undecoded",
			items_sent, mirror.puts, mirror.reads, mirror.blind_reads, mirror.clears,
			mirror.idle_cmds);
		$display("%0d scrolls, %0d row wraps, %0d register writes, %0d results checked, %0d failures",
			mirror.scrolls, mirror.wraps, mirror.reg_writes, mirror.checked, mirror.failures);
		if (mirror.failures == 0 && mirror.due_reports.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### sim.f
rtl/core/tccs_pkg.sv
rtl/core/tccs_ctrl.sv
rtl/core/tccs_dp.sv
rtl/core/text_console_cursor_scroll.sv
sim/text_console_cursor_scroll_tb.sv
